// ===== hdl/a52_pkg.sv =====
// shared types, constants and lfsr helpers for the a5/2 keystream generator
package a52_pkg;

    localparam int KEY_W    = 64;
    localparam int FRAME_W  = 22;
    localparam int LOAD_W   = KEY_W + FRAME_W;
    localparam int WARM_N   = 99;
    localparam int CNT_W    = 7;
    localparam int R1_W     = 19;
    localparam int R2_W     = 22;
    localparam int R3_W     = 23;
    localparam int R4_W     = 17;
    localparam int LFSR_W   = 23;

    localparam logic [KEY_W-1:0]  KEY_RESET = 64'h0000_0012_3456_7890;
    localparam logic [LFSR_W-1:0] TAPS_R1   = 23'h072000;
    localparam logic [LFSR_W-1:0] TAPS_R2   = 23'h300000;
    localparam logic [LFSR_W-1:0] TAPS_R3   = 23'h700080;
    localparam logic [LFSR_W-1:0] TAPS_R4   = 23'h010400;

    localparam logic [CNT_W-1:0] LOAD_LAST = CNT_W'(LOAD_W - 1);
    localparam logic [CNT_W-1:0] WARM_LAST = CNT_W'(WARM_N - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WARM
    } t_state;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic start;     // latch frame and key, clear kept bits
        logic load_bit;  // clock one load bit into all registers
        logic step;      // one cipher step
        logic step_out;  // step also updates kept bits and output word
    } t_dp_cmd;

    function automatic logic maj3(input logic a, input logic b, input logic c);
        maj3 = (a & b) ^ (b & c) ^ (c & a);
    endfunction

    // one lfsr clock: force zero to one, xor input into bit 0, shift in parity
    function automatic logic [LFSR_W-1:0] lfsr_clock(input logic [LFSR_W-1:0] cur,
                                                     input logic              in_bit,
                                                     input logic [LFSR_W-1:0] taps,
                                                     input logic [LFSR_W-1:0] mask);
        logic [LFSR_W-1:0] v;
        logic              fb;
        v = cur;
        if (v == '0) begin
            v = {{(LFSR_W-1){1'b0}}, 1'b1};
        end
        v[0] = v[0] ^ in_bit;
        fb = ^(v & taps);
        lfsr_clock = {v[LFSR_W-2:0], fb} & mask;
    endfunction

endpackage

// ===== hdl/a52_keystream_generator.sv =====
// a5/2 keystream generator top level: sequencer plus lfsr datapath
// generate word: one cipher step in the accept cycle, bit shown on the next cycle
// throughput: one generate word per cycle while the output side keeps taking words
// reinitialize word: busy after accept while the 86 load bits are clocked in and the 99 warm-up steps run
// reset: synchronous active low; lfsrs and kept bits clear, key returns to 0x1234567890
module a52_keystream_generator import a52_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // key write channel, always ready
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [KEY_W-1:0]   i_cipher_key,
    // input words
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_operation,
    input  logic [FRAME_W-1:0] i_frame_number,
    // output words
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_keystream_bit
);

    t_dp_cmd cmd;

    // key register has no conflicts, so writes are taken every cycle
    assign o_cfg_ready = 1'b1;

    // sequencer: owns the handshakes and the load / warm-up counter
    a52_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // datapath: the four lfsrs with majority clocking and the output bit register
    a52_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid & o_cfg_ready),
        .i_cipher_key    (i_cipher_key),
        .i_frame_number  (i_frame_number),
        .i_cmd           (cmd),
        .o_keystream_bit (o_keystream_bit)
    );

endmodule

// ===== hdl/a52_datapath.sv =====
// lfsr datapath: key register, load shifter, four lfsrs, kept bits, output word
module a52_datapath import a52_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [KEY_W-1:0]   i_cipher_key,
    input  logic [FRAME_W-1:0] i_frame_number,
    input  t_dp_cmd            i_cmd,
    output logic               o_keystream_bit
);

    localparam logic [LFSR_W-1:0] MASK_R1 = LFSR_W'((1 << R1_W) - 1);
    localparam logic [LFSR_W-1:0] MASK_R2 = LFSR_W'((1 << R2_W) - 1);
    localparam logic [LFSR_W-1:0] MASK_R3 = LFSR_W'((1 << R3_W) - 1);
    localparam logic [LFSR_W-1:0] MASK_R4 = LFSR_W'((1 << R4_W) - 1);

    logic [KEY_W-1:0]  r_key;
    logic [LOAD_W-1:0] r_load, n_load;
    logic [R1_W-1:0]   r_r1, n_r1;
    logic [R2_W-1:0]   r_r2, n_r2;
    logic [R3_W-1:0]   r_r3, n_r3;
    logic [R4_W-1:0]   r_r4, n_r4;
    logic              r_keep1, n_keep1;
    logic              r_keep2, n_keep2;
    logic              r_keep3, n_keep3;
    logic              r_out_bit, n_out_bit;
    logic              maj_c;
    logic              clk1, clk2, clk3;

    assign maj_c = maj3(r_r4[3], r_r4[7], r_r4[10]);
    assign clk1  = (r_r4[10] == maj_c);
    assign clk2  = (r_r4[3] == maj_c);
    assign clk3  = (r_r4[7] == maj_c);

    always_comb begin
        n_load    = r_load;
        n_r1      = r_r1;
        n_r2      = r_r2;
        n_r3      = r_r3;
        n_r4      = r_r4;
        n_keep1   = r_keep1;
        n_keep2   = r_keep2;
        n_keep3   = r_keep3;
        n_out_bit = r_out_bit;
        if (i_cmd.start) begin
            n_load  = {i_frame_number, r_key};
            n_keep1 = 1'b0;
            n_keep2 = 1'b0;
            n_keep3 = 1'b0;
        end
        if (i_cmd.load_bit) begin
            n_r1   = R1_W'(lfsr_clock(LFSR_W'(r_r1), r_load[0], TAPS_R1, MASK_R1));
            n_r2   = R2_W'(lfsr_clock(LFSR_W'(r_r2), r_load[0], TAPS_R2, MASK_R2));
            n_r3   = R3_W'(lfsr_clock(r_r3, r_load[0], TAPS_R3, MASK_R3));
            n_r4   = R4_W'(lfsr_clock(LFSR_W'(r_r4), r_load[0], TAPS_R4, MASK_R4));
            n_load = r_load >> 1;
        end
        if (i_cmd.step) begin
            if (clk1) begin
                n_r1 = R1_W'(lfsr_clock(LFSR_W'(r_r1), 1'b0, TAPS_R1, MASK_R1));
                if (i_cmd.step_out) begin
                    n_keep1 = r_r1[R1_W-1] ^ maj3(n_r1[12], ~n_r1[14], n_r1[15]);
                end
            end
            if (clk2) begin
                n_r2 = R2_W'(lfsr_clock(LFSR_W'(r_r2), 1'b0, TAPS_R2, MASK_R2));
                if (i_cmd.step_out) begin
                    n_keep2 = r_r2[R2_W-1] ^ maj3(n_r2[9], n_r2[13], ~n_r2[16]);
                end
            end
            if (clk3) begin
                n_r3 = R3_W'(lfsr_clock(r_r3, 1'b0, TAPS_R3, MASK_R3));
                if (i_cmd.step_out) begin
                    n_keep3 = r_r3[R3_W-1] ^ maj3(~n_r3[13], n_r3[16], n_r3[18]);
                end
            end
            n_r4 = R4_W'(lfsr_clock(LFSR_W'(r_r4), 1'b0, TAPS_R4, MASK_R4));
        end
        if (i_cmd.step_out) begin
            n_out_bit = n_keep1 ^ n_keep2 ^ n_keep3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= KEY_RESET;
            r_r1    <= '0;
            r_r2    <= '0;
            r_r3    <= '0;
            r_r4    <= '0;
            r_keep1 <= 1'b0;
            r_keep2 <= 1'b0;
            r_keep3 <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_key <= i_cipher_key;
            end
            r_r1    <= n_r1;
            r_r2    <= n_r2;
            r_r3    <= n_r3;
            r_r4    <= n_r4;
            r_keep1 <= n_keep1;
            r_keep2 <= n_keep2;
            r_keep3 <= n_keep3;
        end
    end

    // payload only
    always_ff @(posedge i_clk) begin
        r_load    <= n_load;
        r_out_bit <= n_out_bit;
    end

    assign o_keystream_bit = r_out_bit;

endmodule

// ===== hdl/a52_ctrl.sv =====
// sequencer: handshakes, load and warm-up counting, datapath commands
module a52_ctrl import a52_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_operation,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;
    logic             in_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        in_acc      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = ~r_out_valid | i_out_ready;
                in_acc     = i_in_valid & o_in_ready;
                if (in_acc) begin
                    if (i_operation) begin
                        o_cmd.start = 1'b1;
                        n_count     = '0;
                        n_state     = ST_LOAD;
                    end else begin
                        o_cmd.step     = 1'b1;
                        o_cmd.step_out = 1'b1;
                        n_out_valid    = 1'b1;
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.load_bit = 1'b1;
                if (r_count == LOAD_LAST) begin
                    n_count = '0;
                    n_state = ST_WARM;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            ST_WARM: begin
                o_cmd.step = 1'b1;
                if (r_count == WARM_LAST) begin
                    n_count = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/a52_checker.sv =====
// port-level checks for the keystream generator, bound to the top level
module a52_checker import a52_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic i_operation,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_keystream_bit
);

    logic in_acc;
    assign in_acc = i_in_valid & o_in_ready;

    // stalled output word stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped while stalled");

    // stalled output bit stays stable
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_keystream_bit))
        else $error("output bit changed while stalled");

    // a generate word gives a result on the next cycle
    a_gen_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_operation |=> o_out_valid)
        else $error("generate word produced no result");

    // a reinitialize word makes the block busy and gives no result
    a_reinit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_operation |=> !o_in_ready && !$rose(o_out_valid))
        else $error("reinitialize word not handled as busy and silent");

endmodule

bind a52_keystream_generator a52_checker u_a52_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_operation     (i_operation),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_keystream_bit (o_keystream_bit)
);
